// ----- hdl/fla_pkg.sv -----
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free list slot allocator: request and
// response items, controller commands and datapath status.
// ----------------------------------------------------------------------------
package fla_pkg;

	// width of a slot index as carried on the ports
	localparam int IDX_W = 6;

	// operation codes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// request item
	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] slot_to_release;
	} fla_req_t;

	// response item
	typedef struct packed {
		logic             granted;
		logic [IDX_W-1:0] slot_index;
		logic             release_rejected;
	} fla_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic init_wr;
		logic capture;
		logic execute;
	} fla_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;
	} fla_sts_t;

endpackage

// ----- hdl/fla_ram.sv -----
// ----------------------------------------------------------------------------
// fla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fla_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 64,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/fla_ctrl.sv -----
// ----------------------------------------------------------------------------
// fla_ctrl
// Controller of the allocator: runs the link table fill after reset, then
// takes one item at a time through a capture and an execute cycle.
// ----------------------------------------------------------------------------
module fla_ctrl
	import fla_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output fla_cmd_t cmd,
	input  fla_sts_t sts
);

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.init_wr = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/fla_dpath.sv -----
// ----------------------------------------------------------------------------
// fla_dpath
// Datapath of the allocator: head pointer, link table, fill counter,
// request register and response register.
// ----------------------------------------------------------------------------
module fla_dpath
	import fla_pkg::*;
#(
	parameter int  SLOT_COUNT = 64,
	localparam int ADDR_W     = $clog2(SLOT_COUNT),
	localparam int LINK_W     = $clog2(SLOT_COUNT + 1)
) (
	input  logic     clk,
	input  logic     arst_n,
	input  fla_cmd_t cmd,
	output fla_sts_t sts,
	input  fla_req_t req,
	output logic     done,
	output fla_rsp_t rsp
);

	localparam int CMP_W = (LINK_W > IDX_W) ? LINK_W : IDX_W;

	logic [LINK_W-1:0] head_q;
	logic [ADDR_W-1:0] sweep_q;
	fla_req_t          req_q;
	fla_rsp_t          rsp_q;
	logic              done_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic [LINK_W-1:0] ram_rdata;

	logic [CMP_W-1:0]  slot_ext;
	logic [CMP_W-1:0]  head_ext;
	logic              is_alloc;
	logic              empty;
	logic              rel_ok;
	logic              do_pop;
	logic              do_push;

	// decode of the captured item
	always_comb begin
		slot_ext = CMP_W'(req_q.slot_to_release);
		head_ext = CMP_W'(head_q);
		is_alloc = (req_q.operation == OP_ALLOC);
		empty    = (head_q >= LINK_W'(SLOT_COUNT));
		rel_ok   = (slot_ext < CMP_W'(SLOT_COUNT));
		do_pop   = cmd.execute && is_alloc && !empty;
		do_push  = cmd.execute && !is_alloc && rel_ok;
	end

	// link table write port: fill sweep, pop marks the slot, push links it
	always_comb begin
		ram_we    = cmd.init_wr || do_pop || do_push;
		ram_waddr = sweep_q;
		ram_wdata = LINK_W'(sweep_q) + LINK_W'(1);
		if (do_pop) begin
			ram_waddr = head_q[ADDR_W-1:0];
			ram_wdata = LINK_W'(SLOT_COUNT);
		end else if (do_push) begin
			ram_waddr = slot_ext[ADDR_W-1:0];
			ram_wdata = head_q;
		end
	end

	assign sts.init_last = (sweep_q == ADDR_W'(SLOT_COUNT - 1));

	fla_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOT_COUNT)
	) u_links (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.capture),
		.raddr (head_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// head pointer and fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.init_wr) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
			if (do_pop) begin
				head_q <= ram_rdata;
			end else if (do_push) begin
				head_q <= slot_ext[LINK_W-1:0];
			end
		end
	end

	// request capture and response register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.execute) begin
			rsp_q.granted          <= do_pop;
			rsp_q.slot_index       <= do_pop ? head_ext[IDX_W-1:0] : '0;
			rsp_q.release_rejected <= !is_alloc && !rel_ok;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- hdl/free_list_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// Fixed pool of slots kept as a singly linked free list in a link table.
// Each accepted item is captured with the link table read at the head,
// then executed; its result is registered on rsp with done. Results are
// strobed and cannot be stalled. A new item is not taken while busy is
// high, which covers the execute step of the item before it.
// Reset: head goes to slot 0, then a fill pass writes all SLOT_COUNT
// entries of the link table while busy stays high.
// ----------------------------------------------------------------------------
module free_list_slot_allocator
	import fla_pkg::*;
#(
	parameter int SLOT_COUNT = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  fla_req_t req,
	output logic     done,
	output fla_rsp_t rsp
);

	fla_cmd_t cmd;
	fla_sts_t sts;

	fla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	fla_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// an accepted item raises busy in the cycle after, blocking the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in work");

	// no grant means index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.granted) |-> (rsp.slot_index == '0))
		else $error("nonzero index without grant");

	// grant and reject never together
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.granted && rsp.release_rejected))
		else $error("grant and reject in one result");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free list slot allocator. Allocate and release
// items are sent in random bursts and phases that drain the pool, refill it
// and push slots twice. A scoreboard keeps its own head pointer and link
// table, predicts every response and compares it field by field with the
// strobed output.
// ----------------------------------------------------------------------------
module tb_top;
	import fla_pkg::*;

	localparam int SLOTS        = 64;
	localparam int RANDOM_ITEMS = 900;
	localparam int LIMIT_CYCLES = 200000;
	localparam int TAIL_CYCLES  = 8;

	// free list mirror and queue of predicted responses
	class slot_pool_scoreboard #(int POOL = 64);
		typedef logic [$clog2(POOL):0] link_t;

		link_t       head;
		link_t       links [POOL];
		fla_rsp_t    predicted_q [$];
		int unsigned mismatches;

		function new();
			head = '0;
			for (int i = 0; i < POOL; i++)
				links[i] = link_t'(i + 1);
			mismatches = 0;
		endfunction

		function int pending();
			return predicted_q.size();
		endfunction

		// update the mirror for an accepted item and queue its response
		function fla_rsp_t note_request(fla_req_t item);
			fla_rsp_t r;
			int       taken;
			int       slot;
			r = '0;
			slot = int'(item.slot_to_release);
			if (item.operation == OP_ALLOC) begin
				if (int'(head) < POOL) begin
					taken = int'(head);
					head = links[taken];
					links[taken] = link_t'(POOL);
					r.granted = 1'b1;
					r.slot_index = taken[IDX_W-1:0];
				end
			end else begin
				if (slot < POOL) begin
					links[slot] = head;
					head = link_t'(slot);
				end else begin
					r.release_rejected = 1'b1;
				end
			end
			predicted_q = {predicted_q, r};
			return r;
		endfunction

		// compare a strobed response with the oldest prediction
		function void check_result(fla_rsp_t got);
			fla_rsp_t exp;
			if (predicted_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response with none pending: ", $time,
						"granted=%0d slot=%0d rejected=%0d",
						got.granted, got.slot_index, got.release_rejected);
				return;
			end
			exp = predicted_q.pop_front();
			if (got.granted !== exp.granted || got.slot_index !== exp.slot_index ||
					got.release_rejected !== exp.release_rejected) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected granted=%0d slot=%0d rejected=%0d, ",
						$time, exp.granted, exp.slot_index, exp.release_rejected,
						"got granted=%0d slot=%0d rejected=%0d",
						got.granted, got.slot_index, got.release_rejected);
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	fla_req_t req;
	logic     done;
	fla_rsp_t rsp;

	slot_pool_scoreboard #(SLOTS) sb;
	int                           held_slots [$];
	int                           burst_left;
	int unsigned                  cycles;

	free_list_slot_allocator #(
		.SLOT_COUNT(SLOTS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response checking
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic fla_req_t make_req(logic op, logic [IDX_W-1:0] slot);
		fla_req_t item;
		item.operation = op;
		item.slot_to_release = slot;
		return item;
	endfunction

	// hold one item until accepted, then maybe leave a gap
	task automatic send_request(input fla_req_t item);
		fla_rsp_t predicted;
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = sb.note_request(item);
		if (predicted.granted)
			held_slots = {held_slots, int'(predicted.slot_index)};
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(40, 80);
			else
				burst_left = $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	// stop sending until every pending response is back
	task automatic wait_for_drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		fla_req_t    item;
		int unsigned sent;
		int unsigned phase_len;
		int unsigned alloc_pct;
		int          pick;
		sb = new();
		cycles = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// first slots in order, then the same slot pushed twice
		send_request(make_req(OP_ALLOC, 6'd0));
		send_request(make_req(OP_ALLOC, 6'd0));
		send_request(make_req(OP_ALLOC, 6'd0));
		send_request(make_req(OP_RELEASE, 6'd1));
		send_request(make_req(OP_RELEASE, 6'd1));
		// self loop on slot 1 empties the pool after two grants
		send_request(make_req(OP_ALLOC, 6'h3F));
		send_request(make_req(OP_ALLOC, 6'd0));
		// never allocated slot 63 and allocated slot 0, at both ends of the index range
		send_request(make_req(OP_RELEASE, 6'd63));
		send_request(make_req(OP_RELEASE, 6'd0));
		// third allocate hits an empty pool
		send_request(make_req(OP_ALLOC, 6'd0));
		send_request(make_req(OP_ALLOC, 6'd0));
		send_request(make_req(OP_ALLOC, 6'h2A));
		send_request(make_req(OP_RELEASE, 6'b101010));
		send_request(make_req(OP_RELEASE, 6'b010101));
		send_request(make_req(OP_ALLOC, 6'h15));
		wait_for_drain();

		// random phases: allocate heavy, release heavy and balanced
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: alloc_pct = 85;
				1: alloc_pct = 20;
				default: alloc_pct = 50;
			endcase
			phase_len = $urandom_range(40, 120);
			repeat (phase_len) begin
				if ($urandom_range(1, 100) <= alloc_pct) begin
					item = make_req(OP_ALLOC, 6'($urandom_range(0, 63)));
				end else if (held_slots.size() != 0 && $urandom_range(0, 9) < 8) begin
					pick = $urandom_range(0, held_slots.size() - 1);
					item = make_req(OP_RELEASE, 6'(held_slots[pick]));
					held_slots.delete(pick);
				end else begin
					// stray release: double push or never allocated
					item = make_req(OP_RELEASE, 6'($urandom_range(0, 63)));
				end
				send_request(item);
			end
			sent += phase_len;
			if ($urandom_range(0, 3) == 0)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/fla_pkg.sv
hdl/fla_ram.sv
hdl/fla_ctrl.sv
hdl/fla_dpath.sv
hdl/free_list_slot_allocator.sv
tb/tb_top.sv
